// ===== sv/rbsi_pkg.sv =====
// Shared types, widths and helpers for the ray / box slab intersection block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rbsi_pkg;

	// default fraction bits of the Q formats
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int Q_W     = 32;            // slab parameter and coordinates
	localparam int EXT_W   = 31;            // box extent registers
	localparam int MAG_W   = 33;            // |+-extent - 2*origin|
	localparam int DEN_W   = 33;            // 2*|dir|
	localparam int SUM_W   = 34;            // signed numerator before magnitude
	localparam int DIV_STAGES = Q_W + 1;    // range check plus one stage per bit
	localparam int AXES    = 3;
	localparam int IDX_W   = 2;

	localparam logic signed [Q_W-1:0] T_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] T_MIN = {1'b1, {(Q_W-1){1'b0}}};

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_BOX_DEPTH  = 2'd2;

	// per-axis flags that travel beside the dividers
	typedef struct packed {
		logic neg_a;    // quotient of the low plane is negative
		logic neg_b;    // quotient of the high plane is negative
		logic dzero;    // direction component is zero
		logic in_slab;  // origin within the slab (used when dzero)
	} slab_side_t;

	typedef struct packed {
		logic signed [Q_W-1:0] val;
		logic                  sat;
	} quot_t;

	// apply the sign to a quotient magnitude and clamp to the signed range
	function automatic quot_t clamp_quot(input logic [Q_W-1:0] mag, input logic neg,
		input logic ovf);
		quot_t r;
		if (neg) begin
			r.sat = ovf | (mag[Q_W-1] & (|mag[Q_W-2:0]));
			r.val = r.sat ? T_MIN : $signed(-mag);
		end else begin
			r.sat = ovf | mag[Q_W-1];
			r.val = r.sat ? T_MAX : $signed(mag);
		end
		return r;
	endfunction

endpackage

// ===== sv/ray_box_slab_intersection.sv =====
// Ray / axis-aligned box slab test, one ray per cycle while the output is not stalled.
// Latency is set by the six 33-stage divider pipelines, one quotient bit per stage.
// Stages advance independently, so bubbles close up under an output stall.
// arst_n clears all valid bits and sets the box extents to 1.0.
// Top level: prepare, divide, clamp and order, narrow by y, narrow by z.
// Depends on rbsi_pkg and rbsi_div.
`timescale 1ns / 1ps

module ray_box_slab_intersection #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbsi_pkg::IDX_W-1:0]      cfg_index,
	input  logic [rbsi_pkg::EXT_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [rbsi_pkg::Q_W-1:0] origin_x,
	input  logic signed [rbsi_pkg::Q_W-1:0] origin_y,
	input  logic signed [rbsi_pkg::Q_W-1:0] origin_z,
	input  logic signed [rbsi_pkg::Q_W-1:0] dir_x,
	input  logic signed [rbsi_pkg::Q_W-1:0] dir_y,
	input  logic signed [rbsi_pkg::Q_W-1:0] dir_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic signed [rbsi_pkg::Q_W-1:0] entry_distance,
	output logic                            saturated
);
	import rbsi_pkg::*;

	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int STAGES = DIV_STAGES + 4;
	localparam int ST_CLAMP = DIV_STAGES + 1;

	// box extent registers
	logic [EXT_W-1:0] ext_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q[0] <= EXT_W'(1 << FRAC_BITS);
			ext_q[1] <= EXT_W'(1 << FRAC_BITS);
			ext_q[2] <= EXT_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_WIDTH:  ext_q[0] <= cfg_wdata;
				REG_BOX_HEIGHT: ext_q[1] <= cfg_wdata;
				REG_BOX_DEPTH:  ext_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage advance, each stage moves when it is free
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] adv;

	always_comb begin
		adv[STAGES-1] = out_ready | ~vld_q[STAGES-1];
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = adv[k+1] | ~vld_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[STAGES-1];

	// prepare: numerator magnitudes, divisor and sign flags per axis
	logic signed [Q_W-1:0] org [AXES];
	logic signed [Q_W-1:0] dir [AXES];

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	logic [NUM_W-1:0] num_a_s1 [AXES];
	logic [NUM_W-1:0] num_b_s1 [AXES];
	logic [DEN_W-1:0] den_s1   [AXES];
	slab_side_t [AXES-1:0] side_s [0:DIV_STAGES];

	for (genvar a = 0; a < AXES; a++) begin : g_prep
		logic signed [SUM_W-1:0] two_o, e, na, nb;
		logic [MAG_W-1:0]        ma, mb;
		logic [Q_W-1:0]          dabs;
		slab_side_t              sd;

		always_comb begin
			two_o = SUM_W'(org[a]) <<< 1;
			e     = $signed(SUM_W'(ext_q[a]));
			na    = -e - two_o;
			nb    = e - two_o;
			ma    = na[SUM_W-1] ? MAG_W'(-na) : MAG_W'(na);
			mb    = nb[SUM_W-1] ? MAG_W'(-nb) : MAG_W'(nb);
			dabs  = dir[a][Q_W-1] ? Q_W'(-dir[a]) : Q_W'(dir[a]);
			sd.neg_a   = na[SUM_W-1] ^ dir[a][Q_W-1];
			sd.neg_b   = nb[SUM_W-1] ^ dir[a][Q_W-1];
			sd.dzero   = (dir[a] == '0);
			sd.in_slab = (two_o >= -e) && (two_o <= e);
		end

		always_ff @(posedge clk) begin
			if (adv[0]) begin
				num_a_s1[a]  <= {ma, {FRAC_BITS{1'b0}}};
				num_b_s1[a]  <= {mb, {FRAC_BITS{1'b0}}};
				den_s1[a]    <= {dabs, 1'b0};
				side_s[0][a] <= sd;
			end
		end
	end

	// carry the flags alongside the dividers
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// six dividers, one per slab plane
	logic [Q_W-1:0] q_a [AXES];
	logic [Q_W-1:0] q_b [AXES];
	logic           ovf_a [AXES];
	logic           ovf_b [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_div
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
			.clk  (clk),
			.adv  (adv[DIV_STAGES:1]),
			.num  (num_a_s1[a]),
			.den  (den_s1[a]),
			.quot (q_a[a]),
			.ovf  (ovf_a[a])
		);
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
			.clk  (clk),
			.adv  (adv[DIV_STAGES:1]),
			.num  (num_b_s1[a]),
			.den  (den_s1[a]),
			.quot (q_b[a]),
			.ovf  (ovf_b[a])
		);
	end

	// clamp, order each slab, handle zero directions
	logic signed [Q_W-1:0] lo_s35 [AXES];
	logic signed [Q_W-1:0] hi_s35 [AXES];
	logic [AXES-1:0]       ok_s35;
	logic [AXES-1:0]       sat_s35;

	for (genvar a = 0; a < AXES; a++) begin : g_clamp
		quot_t      ta, tb;
		slab_side_t sd;

		assign sd = side_s[DIV_STAGES][a];
		assign ta = clamp_quot(q_a[a], sd.neg_a, ovf_a[a]);
		assign tb = clamp_quot(q_b[a], sd.neg_b, ovf_b[a]);

		always_ff @(posedge clk) begin
			if (adv[ST_CLAMP]) begin
				if (sd.dzero) begin
					lo_s35[a]  <= T_MIN;
					hi_s35[a]  <= T_MAX;
					ok_s35[a]  <= sd.in_slab;
					sat_s35[a] <= 1'b0;
				end else begin
					lo_s35[a]  <= (ta.val > tb.val) ? tb.val : ta.val;
					hi_s35[a]  <= (ta.val > tb.val) ? ta.val : tb.val;
					ok_s35[a]  <= 1'b1;
					sat_s35[a] <= ta.sat | tb.sat;
				end
			end
		end
	end

	// narrow the x interval by y
	logic signed [Q_W-1:0] tmin_s36, tmax_s36, lo_z_s36, hi_z_s36;
	logic                  hit_s36, ok_z_s36, sat_s36;

	always_ff @(posedge clk) begin
		if (adv[ST_CLAMP+1]) begin
			tmin_s36 <= (lo_s35[1] > lo_s35[0]) ? lo_s35[1] : lo_s35[0];
			tmax_s36 <= (hi_s35[1] < hi_s35[0]) ? hi_s35[1] : hi_s35[0];
			hit_s36  <= ok_s35[0] & ok_s35[1] & ~(lo_s35[0] > hi_s35[1])
				& ~(lo_s35[1] > hi_s35[0]);
			lo_z_s36 <= lo_s35[2];
			hi_z_s36 <= hi_s35[2];
			ok_z_s36 <= ok_s35[2];
			sat_s36  <= |sat_s35;
		end
	end

	// narrow by z and hold the result for the consumer
	logic                  hit_s37, sat_s37;
	logic signed [Q_W-1:0] tmin_s37;
	logic                  hz;

	assign hz = hit_s36 & ok_z_s36 & ~(tmin_s36 > hi_z_s36) & ~(lo_z_s36 > tmax_s36);

	always_ff @(posedge clk) begin
		if (adv[ST_CLAMP+2]) begin
			hit_s37  <= hz;
			tmin_s37 <= !hz ? '0 : ((lo_z_s36 > tmin_s36) ? lo_z_s36 : tmin_s36);
			sat_s37  <= sat_s36;
		end
	end

	assign hit            = hit_s37;
	assign entry_distance = tmin_s37;
	assign saturated      = sat_s37;

endmodule

// ===== sv/rbsi_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rbsi_pkg; stage advance enables come from the top level.
`timescale 1ns / 1ps

module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic [rbsi_pkg::DIV_STAGES-1:0]        adv,
	input  logic [rbsi_pkg::MAG_W+FRAC_BITS-1:0]   num,
	input  logic [rbsi_pkg::DEN_W-1:0]             den,
	output logic [rbsi_pkg::Q_W-1:0]               quot,
	output logic                                   ovf
);
	import rbsi_pkg::*;

	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int REM_W = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W + 1;

	logic [REM_W-1:0] rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic             ovf_s [0:Q_W];

	// range check: a quotient that does not fit in Q_W bits saturates
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0] <= REM_W'(num);
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= REM_W'(num) >= (REM_W'(den) << Q_W);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= Q_W; j++) begin : g_step
		localparam int B = Q_W - j;
		logic [REM_W-1:0] sub;
		logic             take;

		assign sub  = REM_W'(den_s[j-1]) << B;
		assign take = rem_s[j-1] >= sub;

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j] <= take ? rem_s[j-1] - sub : rem_s[j-1];
				den_s[j] <= den_s[j-1];
				q_s[j]   <= q_s[j-1] | (Q_W'(take) << B);
				ovf_s[j] <= ovf_s[j-1];
			end
		end
	end

	assign quot = q_s[Q_W];
	assign ovf  = ovf_s[Q_W];

endmodule
